// ----- hdl/hvd_pkg.sv -----
// Shared constants and helpers for the 3D haversine distance pipeline.
// No dependencies; used by the CORDIC modules, the top level and the checker.
`default_nettype none

package hvd_pkg;

	// Q30 fixed-point angle constants
	localparam logic [31:0] PI_Q30       = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
	localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

	// 1e-7 degree to radians, scaled by 2^61
	localparam logic [31:0] DEG7_TO_RAD_Q61 = 32'd4024455254;

	localparam logic signed [34:0] TURN_DEG7      = 35'sd3600000000;
	localparam logic signed [34:0] HALF_TURN_DEG7 = 35'sd1800000000;

	localparam logic [22:0] RADIUS_RESET = 23'd6371000;
	localparam logic [34:0] DIST_MAX     = '1;

	localparam logic [29:0] ATAN_TABLE [16] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
		30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
		30'd262143,    30'd131071,    30'd65535,     30'd32767
	};

	// atan(2^-i) in Q30; past the table it is 2^(30-i), then zero
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] r;
		if (i < 16) begin
			r = {2'b00, ATAN_TABLE[i[3:0]]};
		end else if (i <= 30) begin
			r = 32'd1 << (30 - i);
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/hvd_rot_cordic.sv -----
// Pipelined CORDIC rotation, one iteration per stage, several lanes in lockstep.
// Uses hvd_pkg for the gain and arctangent constants.
`default_nettype none

module hvd_rot_cordic #(
	parameter int STEPS = 32,
	parameter int LANES = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   ce,
	input  wire logic                   in_vld,
	input  wire logic [LANES-1:0][31:0] ang,   // Q30, at most pi/2
	input  wire logic [LANES-1:0]       flip,  // negate cosine on the way out
	output logic                        out_vld,
	output logic [LANES-1:0][32:0]      sin_val,
	output logic [LANES-1:0][32:0]      cos_val
);

	localparam int W = 33;

	logic signed [W-1:0] x_s [STEPS+1][LANES];
	logic signed [W-1:0] y_s [STEPS+1][LANES];
	logic signed [W-1:0] z_s [STEPS+1][LANES];
	logic [LANES-1:0]    flip_s [STEPS+1];
	logic [LANES-1:0][W-1:0] sin_s;
	logic [LANES-1:0][W-1:0] cos_s;
	logic [STEPS+1:0]    vld_s;

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < LANES; l++) begin
				x_s[0][l] <= hvd_pkg::GAIN_Q30;
				y_s[0][l] <= '0;
				z_s[0][l] <= W'(ang[l]);
			end
			flip_s[0] <= flip;
			for (int k = 0; k < STEPS; k++) begin
				for (int l = 0; l < LANES; l++) begin
					if (!z_s[k][l][W-1]) begin
						x_s[k+1][l] <= x_s[k][l] - (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] + (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] - W'(hvd_pkg::atan_q30(k));
					end else begin
						x_s[k+1][l] <= x_s[k][l] + (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] - (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] + W'(hvd_pkg::atan_q30(k));
					end
				end
				flip_s[k+1] <= flip_s[k];
			end
			for (int l = 0; l < LANES; l++) begin
				sin_s[l] <= y_s[STEPS][l];
				cos_s[l] <= flip_s[STEPS][l] ? -x_s[STEPS][l] : x_s[STEPS][l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[STEPS:0], in_vld};
		end
	end

	assign out_vld = vld_s[STEPS+1];
	assign sin_val = sin_s;
	assign cos_val = cos_s;

endmodule

`default_nettype wire

// ----- hdl/hvd_vec_cordic.sv -----
// Pipelined CORDIC vectoring: angle of a non-negative (x, y) pair in Q30.
// Uses hvd_pkg for the arctangent constants.
`default_nettype none

module hvd_vec_cordic #(
	parameter int STEPS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        ce,
	input  wire logic        in_vld,
	input  wire logic [31:0] x_in,
	input  wire logic [31:0] y_in,
	output logic             out_vld,
	output logic [32:0]      angle
);

	localparam int W  = 35;
	localparam int ZW = 33;

	logic signed [W-1:0]  x_s [STEPS+1];
	logic signed [W-1:0]  y_s [STEPS+1];
	logic signed [ZW-1:0] z_s [STEPS+1];
	logic [STEPS:0]       vld_s;

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s[0] <= W'(x_in);
			y_s[0] <= W'(y_in);
			z_s[0] <= '0;
			for (int k = 0; k < STEPS; k++) begin
				if (!y_s[k][W-1]) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + ZW'(hvd_pkg::atan_q30(k));
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - ZW'(hvd_pkg::atan_q30(k));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[STEPS-1:0], in_vld};
		end
	end

	assign out_vld = vld_s[STEPS];
	assign angle   = z_s[STEPS];

endmodule

`default_nettype wire

// ----- hdl/hvd_sqrt.sv -----
// Pipelined radix-4 square root, one digit per stage, rounded to nearest.
// Stand-alone; no package items needed.
`default_nettype none

module hvd_sqrt #(
	parameter int PAIRS = 31,
	parameter int LANES = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         ce,
	input  wire logic                         in_vld,
	input  wire logic [LANES-1:0][2*PAIRS-1:0] rad,
	output logic                              out_vld,
	output logic [LANES-1:0][PAIRS:0]         root
);

	localparam int RW = PAIRS + 2;

	logic [2*PAIRS-1:0] rad_s  [PAIRS+1][LANES];
	logic [RW-1:0]      rem_s  [PAIRS+1][LANES];
	logic [PAIRS-1:0]   root_s [PAIRS+1][LANES];
	logic [RW-1:0]      rsh_c  [PAIRS][LANES];
	logic [RW-1:0]      trial_c [PAIRS][LANES];
	logic [LANES-1:0][PAIRS:0] res_s;
	logic [PAIRS+1:0]   vld_s;

	always_comb begin
		for (int k = 0; k < PAIRS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				rsh_c[k][l]   = {rem_s[k][l][RW-3:0], rad_s[k][l][2*PAIRS-1 -: 2]};
				trial_c[k][l] = {root_s[k][l], 2'b01};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < LANES; l++) begin
				rad_s[0][l]  <= rad[l];
				rem_s[0][l]  <= '0;
				root_s[0][l] <= '0;
			end
			for (int k = 0; k < PAIRS; k++) begin
				for (int l = 0; l < LANES; l++) begin
					rad_s[k+1][l] <= rad_s[k][l] << 2;
					if (rsh_c[k][l] >= trial_c[k][l]) begin
						rem_s[k+1][l]  <= rsh_c[k][l] - trial_c[k][l];
						root_s[k+1][l] <= {root_s[k][l][PAIRS-2:0], 1'b1};
					end else begin
						rem_s[k+1][l]  <= rsh_c[k][l];
						root_s[k+1][l] <= {root_s[k][l][PAIRS-2:0], 1'b0};
					end
				end
			end
			// round to nearest: remainder above the root means the next half step
			for (int l = 0; l < LANES; l++) begin
				if (rem_s[PAIRS][l] > RW'(root_s[PAIRS][l])) begin
					res_s[l] <= {1'b0, root_s[PAIRS][l]} + (PAIRS+1)'(1);
				end else begin
					res_s[l] <= {1'b0, root_s[PAIRS][l]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[PAIRS:0], in_vld};
		end
	end

	assign out_vld = vld_s[PAIRS+1];
	assign root    = res_s;

endmodule

`default_nettype wire

// ----- hdl/haversine_distance_3d.sv -----
// Top level of the 3D haversine distance pipeline.
// Depends on hvd_pkg, hvd_rot_cordic, hvd_sqrt and hvd_vec_cordic.
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      point pair: lat_a, lon_a, alt_a, lat_b, lon_b, alt_b
// m_*       out  tvalid/tready      distance_mm
// cfg_*     in   cfg_wen            sphere_radius_m, no read-back
//
// One request per cycle while the skid entry is empty; s_tready is low otherwise. m_tvalid
// rises for a request once it has run through the two CORDIC pipelines and the
// two digit-per-stage square roots. Reset clears all valid bits and loads the default radius.
// A two-entry output (register plus skid) lets requests keep entering while one
// result waits; the whole pipe freezes only once the skid entry is taken.
`default_nettype none

module haversine_distance_3d #(
	parameter int CORDIC_STEPS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [22:0]  cfg_wdata,   // sphere_radius_m
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// lat_a[30:0] lon_a[62:31] alt_a[89:63] lat_b[120:90] lon_b[152:121]
	// alt_b[179:153], zero fill [183:180]
	input  wire logic [183:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// distance_mm[34:0], zero fill [39:35]
	output logic [39:0]       m_tdata
);

	// first square root sees (a << 30) with a at most 2^30: 31 digit pairs
	localparam int SQ1_PAIRS = 31;
	localparam int SQ2_PAIRS = 36;
	// dv travels beside: rotation, products, first root, vectoring, scaling
	localparam int DV_DLY = 2 * CORDIC_STEPS + SQ1_PAIRS + 11;

	logic [22:0] radius_q;
	logic        ce;

	// ---------------- input unpack ----------------
	logic signed [30:0] lat_a, lat_b;
	logic signed [31:0] lon_a, lon_b;
	logic signed [26:0] alt_a, alt_b;

	assign lat_a = s_tdata[30:0];
	assign lon_a = s_tdata[62:31];
	assign alt_a = s_tdata[89:63];
	assign lat_b = s_tdata[120:90];
	assign lon_b = s_tdata[152:121];
	assign alt_b = s_tdata[179:153];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hvd_pkg::RADIUS_RESET;
		end else if (cfg_wen) begin
			radius_q <= cfg_wdata;
		end
	end

	// ---------------- prep: differences, turn reduction, degrees to radians --
	logic               vld_p1, vld_p2, vld_p3, vld_p4;
	logic signed [32:0] dlat_p1;
	logic signed [33:0] dlon_p1;
	logic signed [30:0] lata_p1, latb_p1;
	logic signed [27:0] dalt_p1;

	logic signed [34:0] red_c [2];
	logic signed [34:0] sgn_c [4];
	logic [30:0]        mag_c [4];
	logic [30:0]        mag_p2 [4];
	logic [26:0]        dv_p2, dv_p3, dv_p4;
	logic [62:0]        prod_p3 [4];
	logic [63:0]        rnd_c [4];
	logic [31:0]        rad_c [4];
	logic [3:0][31:0]   ang_p4;
	logic [3:0]         flip_p4;

	always_ff @(posedge clk) begin
		if (ce) begin
			dlat_p1 <= 33'(lat_b) - 33'(lat_a);
			dlon_p1 <= 34'(lon_b) - 34'(lon_a);
			lata_p1 <= lat_a;
			latb_p1 <= lat_b;
			dalt_p1 <= 28'(alt_b) - 28'(alt_a);
		end
	end

	always_comb begin
		sgn_c[0] = 35'(dlat_p1);
		sgn_c[1] = 35'(dlon_p1);
		// a difference past half a turn wraps by one turn
		for (int l = 0; l < 2; l++) begin
			if (sgn_c[l] > hvd_pkg::HALF_TURN_DEG7) begin
				red_c[l] = sgn_c[l] - hvd_pkg::TURN_DEG7;
			end else if (sgn_c[l] < -hvd_pkg::HALF_TURN_DEG7) begin
				red_c[l] = sgn_c[l] + hvd_pkg::TURN_DEG7;
			end else begin
				red_c[l] = sgn_c[l];
			end
		end
		sgn_c[2] = 35'(lata_p1);
		sgn_c[3] = 35'(latb_p1);
		for (int l = 0; l < 4; l++) begin
			if (l < 2) begin
				mag_c[l] = red_c[l][34] ? 31'(-red_c[l]) : red_c[l][30:0];
			end else begin
				mag_c[l] = sgn_c[l][34] ? 31'(-sgn_c[l]) : sgn_c[l][30:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < 4; l++) begin
				mag_p2[l]  <= mag_c[l];
				prod_p3[l] <= 63'(mag_p2[l]) * 63'(hvd_pkg::DEG7_TO_RAD_Q61);
			end
			dv_p2 <= dalt_p1[27] ? 27'(-dalt_p1) : dalt_p1[26:0];
			dv_p3 <= dv_p2;
			dv_p4 <= dv_p3;
		end
	end

	// half angles (lanes 0, 1) drop one more bit; fold angles above pi/2
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (l < 2) begin
				rnd_c[l] = 64'(prod_p3[l]) + 64'h0000_0000_8000_0000;
				rad_c[l] = rnd_c[l][63:32];
			end else begin
				rnd_c[l] = 64'(prod_p3[l]) + 64'h0000_0000_4000_0000;
				rad_c[l] = rnd_c[l][62:31];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < 4; l++) begin
				if (rad_c[l] > hvd_pkg::HALF_PI_Q30) begin
					ang_p4[l]  <= hvd_pkg::PI_Q30 - rad_c[l];
					flip_p4[l] <= 1'b1;
				end else begin
					ang_p4[l]  <= rad_c[l];
					flip_p4[l] <= 1'b0;
				end
			end
		end
	end

	// ---------------- sin/cos: lanes dlat/2, dlon/2, lat_a, lat_b ----------
	logic             rot_vld;
	logic [3:0][32:0] sin_v, cos_v;

	hvd_rot_cordic #(
		.STEPS (CORDIC_STEPS),
		.LANES (4)
	) u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (vld_p4),
		.ang     (ang_p4),
		.flip    (flip_p4),
		.out_vld (rot_vld),
		.sin_val (sin_v),
		.cos_val (cos_v)
	);

	// ---------------- haversine term a ----------------
	logic               vld_m1, vld_m2, vld_m3, vld_m4;
	logic signed [65:0] sq1_m1, sq2_m1, cc_m1;
	logic signed [65:0] sq1_c, sq2_c, cc_c;
	logic signed [32:0] s1q_m2, s2q_m2, cc_m2, s1q_m3;
	logic signed [65:0] ccs_m3;
	logic signed [65:0] ccs_c;
	logic signed [35:0] a_c;
	logic [30:0]        a_m4;

	always_ff @(posedge clk) begin
		if (ce) begin
			sq1_m1 <= $signed(sin_v[0]) * $signed(sin_v[0]);
			sq2_m1 <= $signed(sin_v[1]) * $signed(sin_v[1]);
			cc_m1  <= $signed(cos_v[2]) * $signed(cos_v[3]);
		end
	end

	assign sq1_c = sq1_m1 + 66'sh2000_0000;
	assign sq2_c = sq2_m1 + 66'sh2000_0000;
	assign cc_c  = cc_m1 + 66'sh2000_0000;

	always_ff @(posedge clk) begin
		if (ce) begin
			s1q_m2 <= sq1_c[62:30];
			s2q_m2 <= sq2_c[62:30];
			cc_m2  <= cc_c[62:30];
			ccs_m3 <= cc_m2 * s2q_m2;
			s1q_m3 <= s1q_m2;
		end
	end

	assign ccs_c = ccs_m3 + 66'sh2000_0000;
	assign a_c   = 36'(s1q_m3) + ccs_c[65:30];

	// clamp to [0, 1] in Q30
	always_ff @(posedge clk) begin
		if (ce) begin
			if (a_c[35]) begin
				a_m4 <= '0;
			end else if (a_c > 36'sd1073741824) begin
				a_m4 <= 31'd1073741824;
			end else begin
				a_m4 <= a_c[30:0];
			end
		end
	end

	// ---------------- sqrt(a), sqrt(1-a) ----------------
	logic                         sq1_vld;
	logic [1:0][2*SQ1_PAIRS-1:0]  sq1_rad;
	logic [1:0][SQ1_PAIRS:0]      sq1_root;
	logic [30:0]                  one_minus_a;

	assign one_minus_a = 31'd1073741824 - a_m4;
	assign sq1_rad[0]  = {1'b0, a_m4, 30'd0};
	assign sq1_rad[1]  = {1'b0, one_minus_a, 30'd0};

	hvd_sqrt #(
		.PAIRS (SQ1_PAIRS),
		.LANES (2)
	) u_sqrt_hav (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (vld_m4),
		.rad     (sq1_rad),
		.out_vld (sq1_vld),
		.root    (sq1_root)
	);

	// ---------------- central angle ----------------
	logic        vec_vld;
	logic [32:0] vec_ang;

	hvd_vec_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_vec (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (sq1_vld),
		.x_in    (sq1_root[1]),
		.y_in    (sq1_root[0]),
		.out_vld (vec_vld),
		.angle   (vec_ang)
	);

	// ---------------- scale to millimetres ----------------
	logic        vld_sc1, vld_sc2;
	logic [31:0] zc_c;
	logic [55:0] p_sc1;
	logic [62:0] p125_c;
	logic [35:0] h_sc2;

	// a slightly negative angle from rounding counts as zero
	assign zc_c = vec_ang[32] ? 32'd0 : vec_ang[31:0];

	// p*125 >> 27 is p*1000 >> 30 with the 2 of 2z folded in
	assign p125_c = 63'(p_sc1) * 63'd125 + 63'h400_0000;

	always_ff @(posedge clk) begin
		if (ce) begin
			p_sc1 <= 56'(radius_q) * 56'({zc_c, 1'b0});
			h_sc2 <= p125_c[62:27];
		end
	end

	// altitude difference delay line
	logic [26:0] dv_line_q [DV_DLY];

	always_ff @(posedge clk) begin
		if (ce) begin
			dv_line_q[0] <= dv_p4;
			for (int i = 1; i < DV_DLY; i++) begin
				dv_line_q[i] <= dv_line_q[i-1];
			end
		end
	end

	// ---------------- sum of squares, split into 18-bit halves ----------------
	logic        vld_q1, vld_q2;
	logic [35:0] hhh_q1, hhl_q1, hll_q1;
	logic [53:0] dvsq_q1;
	logic [71:0] sum_q2;

	always_ff @(posedge clk) begin
		if (ce) begin
			hhh_q1  <= 36'(h_sc2[35:18]) * 36'(h_sc2[35:18]);
			hhl_q1  <= 36'(h_sc2[35:18]) * 36'(h_sc2[17:0]);
			hll_q1  <= 36'(h_sc2[17:0]) * 36'(h_sc2[17:0]);
			dvsq_q1 <= 54'(dv_line_q[DV_DLY-1]) * 54'(dv_line_q[DV_DLY-1]);
			sum_q2  <= {hhh_q1, 36'd0} + {17'd0, hhl_q1, 19'd0}
				+ 72'(hll_q1) + 72'(dvsq_q1);
		end
	end

	// ---------------- 3D distance ----------------
	logic                    sq2_vld;
	logic [0:0][71:0]        sq2_rad;
	logic [0:0][SQ2_PAIRS:0] sq2_root;
	logic [34:0]             dist_c;

	assign sq2_rad[0] = sum_q2;

	hvd_sqrt #(
		.PAIRS (SQ2_PAIRS),
		.LANES (1)
	) u_sqrt_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (vld_q2),
		.rad     (sq2_rad),
		.out_vld (sq2_vld),
		.root    (sq2_root)
	);

	assign dist_c = (sq2_root[0][SQ2_PAIRS:35] != '0) ? hvd_pkg::DIST_MAX
		: sq2_root[0][34:0];

	// ---------------- valid bits of the top-level stages ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1  <= 1'b0;
			vld_p2  <= 1'b0;
			vld_p3  <= 1'b0;
			vld_p4  <= 1'b0;
			vld_m1  <= 1'b0;
			vld_m2  <= 1'b0;
			vld_m3  <= 1'b0;
			vld_m4  <= 1'b0;
			vld_sc1 <= 1'b0;
			vld_sc2 <= 1'b0;
			vld_q1  <= 1'b0;
			vld_q2  <= 1'b0;
		end else if (ce) begin
			vld_p1  <= s_tvalid;
			vld_p2  <= vld_p1;
			vld_p3  <= vld_p2;
			vld_p4  <= vld_p3;
			vld_m1  <= rot_vld;
			vld_m2  <= vld_m1;
			vld_m3  <= vld_m2;
			vld_m4  <= vld_m3;
			vld_sc1 <= vec_vld;
			vld_sc2 <= vld_sc1;
			vld_q1  <= vld_sc2;
			vld_q2  <= vld_q1;
		end
	end

	// ---------------- output register and skid entry ----------------
	logic        out_vld_q, sk_vld_q;
	logic [34:0] out_q, sk_q;
	logic        push;

	assign ce   = ~sk_vld_q;
	assign push = sq2_vld & ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else begin
			if (m_tready || !out_vld_q) begin
				out_vld_q <= sk_vld_q | push;
			end
			if (sk_vld_q) begin
				if (m_tready) begin
					sk_vld_q <= 1'b0;
				end
			end else if (push && out_vld_q && !m_tready) begin
				sk_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_vld_q) begin
			out_q <= sk_vld_q ? sk_q : dist_c;
		end
		if (!sk_vld_q && push && out_vld_q && !m_tready) begin
			sk_q <= dist_c;
		end
	end

	assign s_tready = ce;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_q};

`ifndef NO_ASSERTIONS
	// skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_vld_q |-> out_vld_q)
		else $error("skid entry valid without output valid");

	// a result arriving at a stalled, full output must land in the skid entry
	a_push_captured: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !m_tready && push |=> sk_vld_q)
		else $error("result dropped at stalled output");

	// radius changes only through the configuration port
	a_radius_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wen |=> radius_q == $past(radius_q))
		else $error("radius changed without a write");
`endif

endmodule

`default_nettype wire

// ----- dv/hvd_checker.sv -----
// Checker for haversine_distance_3d: bit-exact distance predictor and in-order compare.
// Depends on hvd_pkg (angle constants and arctangent table).
`timescale 1ns / 100ps

module hvd_checker #(
	parameter int CORDIC_STEPS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [22:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [183:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [39:0]  m_tdata,
	output int                fails,
	output int                pending,
	output int                checked
);

	logic [22:0] radius_m;
	logic [34:0] dist_queue[$];

	function automatic longint arc_step(input int i);
		if (i < 16)
			return longint'(hvd_pkg::ATAN_TABLE[i]);
		else if (i <= 30)
			return longint'(64'sd1 <<< (30 - i));
		return 0;
	endfunction

	function automatic void rotate_angle(input longint ang, output longint s, output longint c);
		longint x, y, z, xs, ys;
		bit flip;
		flip = ang > longint'(hvd_pkg::HALF_PI_Q30);
		if (flip)
			ang = longint'(hvd_pkg::PI_Q30) - ang;
		x = longint'(hvd_pkg::GAIN_Q30);
		y = 0;
		z = ang;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arc_step(i);
			end else begin
				x += ys; y -= xs; z += arc_step(i);
			end
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint vector_arc(input longint x, input longint y);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += arc_step(i);
			end else begin
				x -= ys; y += xs; z -= arc_step(i);
			end
		end
		return z;
	endfunction

	// radix-4 recurrence, rounded to nearest
	function automatic logic [63:0] root_round(input logic [71:0] v);
		logic [63:0] root, rem, trial;
		root = 0;
		rem = 0;
		for (int i = 35; i >= 0; i--) begin
			rem = (rem << 2) | 64'(v[2*i +: 2]);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		if (rem > root)
			root++;
		return root;
	endfunction

	function automatic longint wrap_turn(input longint d);
		if (d > longint'(hvd_pkg::HALF_TURN_DEG7))
			return d - longint'(hvd_pkg::TURN_DEG7);
		if (d < -longint'(hvd_pkg::HALF_TURN_DEG7))
			return d + longint'(hvd_pkg::TURN_DEG7);
		return d;
	endfunction

	// |deg7| to Q30 radians; half selects the half angle
	function automatic longint deg7_to_q30(input longint d, input bit half);
		logic [63:0] mag, prod;
		int sh;
		mag = d < 0 ? -d : d;
		sh = half ? 32 : 31;
		prod = mag * 64'(hvd_pkg::DEG7_TO_RAD_Q61) + (64'd1 << (sh - 1));
		return longint'(prod >> sh);
	endfunction

	function automatic logic [34:0] predict_distance(input logic [183:0] d,
			input logic [22:0] radius);
		longint lat_a, lon_a, alt_a, lat_b, lon_b, alt_b;
		longint s1, s2, c1, c2, junk, s1q, s2q, cc, hav, z, dv;
		logic [63:0] sa, sb, p, h, root;
		logic [71:0] sum;
		lat_a = longint'($signed(d[30:0]));
		lon_a = longint'($signed(d[62:31]));
		alt_a = longint'($signed(d[89:63]));
		lat_b = longint'($signed(d[120:90]));
		lon_b = longint'($signed(d[152:121]));
		alt_b = longint'($signed(d[179:153]));
		rotate_angle(deg7_to_q30(wrap_turn(lat_b - lat_a), 1), s1, junk);
		rotate_angle(deg7_to_q30(wrap_turn(lon_b - lon_a), 1), s2, junk);
		rotate_angle(deg7_to_q30(lat_a, 0), junk, c1);
		rotate_angle(deg7_to_q30(lat_b, 0), junk, c2);
		s1q = (s1 * s1 + (64'sd1 <<< 29)) >>> 30;
		s2q = (s2 * s2 + (64'sd1 <<< 29)) >>> 30;
		cc = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
		hav = s1q + ((cc * s2q + (64'sd1 <<< 29)) >>> 30);
		if (hav < 0)
			hav = 0;
		if (hav > (64'sd1 <<< 30))
			hav = 64'sd1 <<< 30;
		sa = root_round(72'(64'(hav) << 30));
		sb = root_round(72'(64'((64'sd1 <<< 30) - hav) << 30));
		z = vector_arc(longint'(sb), longint'(sa));
		if (z < 0)
			z = 0;
		p = 64'(radius) * (64'd2 * 64'(z));
		h = (p * 64'd125 + (64'd1 << 26)) >> 27;
		dv = alt_b - alt_a;
		if (dv < 0)
			dv = -dv;
		sum = 72'(h) * 72'(h) + 72'(dv) * 72'(dv);
		root = root_round(sum);
		if (root > 64'(hvd_pkg::DIST_MAX))
			root = 64'(hvd_pkg::DIST_MAX);
		return root[34:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [34:0] want;
		if (!arst_n) begin
			radius_m <= hvd_pkg::RADIUS_RESET;
			fails = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_wen)
				radius_m <= cfg_wdata;
			if (s_tvalid && s_tready)
				dist_queue.push_back(predict_distance(s_tdata, radius_m));
			if (m_tvalid && m_tready) begin
				checked++;
				if (dist_queue.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result distance_mm=%0d", $time,
							m_tdata[34:0]);
				end else begin
					want = dist_queue.pop_front();
					if (want !== m_tdata[34:0]) begin
						fails++;
						if (fails <= 10)
							$display("%0t: distance_mm expected %0d got %0d", $time,
								want, m_tdata[34:0]);
					end
				end
			end
			pending = dist_queue.size();
		end
	end
endmodule

// ----- dv/testbench.sv -----
// Top of the haversine_distance_3d bench: clock, reset, requests, radius phases, verdict.
// Depends on hvd_pkg, hvd_checker and the RTL under hdl/.
`timescale 1ns / 100ps

module testbench;

	localparam int LATENCY = 2 * 32 + 87;
	localparam int WATCHDOG = 20000;

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [22:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [183:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;

	int  fails, pending, checked;
	int  sent;
	int  quiet_cycles;
	bit  rx_hold;      // long receiver hold-off
	bit  no_idle;      // stretch with no idling on either side

	haversine_distance_3d uut (.*);

	hvd_checker chk (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random back-pressure, held off entirely while rx_hold is set
	always @(posedge clk) begin
		if (rx_hold)
			m_tready <= 1'b0;
		else if (no_idle)
			m_tready <= 1'b1;
		else
			m_tready <= $urandom_range(0, 99) >= 11;
	end

	// watchdog: cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (arst_n && ++quiet_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d results outstanding", pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [183:0] pack_pair(input logic [30:0] lat_a,
			input logic [31:0] lon_a, input logic [26:0] alt_a, input logic [30:0] lat_b,
			input logic [31:0] lon_b, input logic [26:0] alt_b);
		return {4'b0, alt_b, lon_b, lat_b, alt_a, lon_a, lat_a};
	endfunction

	// mostly in-range fields, sometimes any bit pattern
	function automatic logic [183:0] random_pair();
		logic [30:0] la, lb;
		logic [31:0] oa, ob;
		logic [26:0] aa, ab;
		if ($urandom_range(0, 9) == 0) begin
			la = 31'($urandom()); lb = 31'($urandom());
			oa = $urandom(); ob = $urandom();
			aa = 27'($urandom()); ab = 27'($urandom());
		end else begin
			la = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
			lb = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
			oa = 32'(longint'($urandom_range(0, 3600000000)) - 1800000000);
			ob = 32'(longint'($urandom_range(0, 3600000000)) - 1800000000);
			if ($urandom_range(0, 3) == 0) begin
				// nearby points: small deltas exercise the small-angle path
				lb = la + 31'($urandom_range(0, 2000) - 1000);
				ob = oa + 32'($urandom_range(0, 2000) - 1000);
			end
			aa = 27'($urandom_range(0, 50500000) - 500000);
			ab = 27'($urandom_range(0, 50500000) - 500000);
		end
		return pack_pair(la, oa, aa, lb, ob, ab);
	endfunction

	task automatic send(input logic [183:0] pair);
		if (!no_idle && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pair;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_radius(input logic [22:0] r);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [22:0] radii[6];
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		rx_hold = 1'b0;
		no_idle = 1'b0;
		sent = 0;
		quiet_cycles = 0;
		radii = '{23'd6000000, 23'd7000000, 23'd0, 23'h7FFFFF, 23'd6371000, 23'd6500000};
		wait (arst_n);
		@(posedge clk);

		// directed requests at the reset radius
		send(pack_pair('0, '0, '0, '0, '0, '0));
		send(pack_pair(31'(900000000), '0, '0, 31'(-900000000), '0, '0));     // pole to pole
		send(pack_pair('0, '0, '0, '0, 32'd1800000000, '0));                  // antipodal
		send(pack_pair('0, 32'(-1800000000), '0, '0, 32'd1800000000, '0));    // same meridian
		send(pack_pair('0, 32'(-1700000000), '0, '0, 32'd1700000000, '0));    // wraps the turn
		send(pack_pair(31'(800000000), '0, '0, 31'(-800000000), '0, '0));
		send(pack_pair(31'h3FFFFFFF, '0, '0, 31'h40000000, '0, '0));          // lat past 90
		send(pack_pair(31'h40000000, 32'h80000000, 27'h4000000,
			31'h3FFFFFFF, 32'h7FFFFFFF, 27'h3FFFFFF));                         // field extremes
		send(pack_pair(31'h7FFFFFFF, 32'hFFFFFFFF, 27'h7FFFFFF, '0, '0, '0));
		send(pack_pair('0, '0, 27'(-500000), '0, '0, 27'd50000000));          // altitude only
		send(pack_pair(31'd12345, 32'd67890, 27'd1000,
			31'd12345, 32'd67890, 27'd1000));                                  // same point
		send(pack_pair('0, '0, '0, 31'd1, '0, '0));                           // smallest step
		send(pack_pair('0, '0, '0, '0, 32'd1, '0));
		send(pack_pair(31'(900000000), 32'd900000000, '0,
			31'(900000000), 32'(-900000000), '0));
		send(pack_pair(31'(-450000000), 32'd1799999999, 27'd50000000,
			31'(450000000), 32'(-1799999999), 27'(-500000)));
		drain();                                                             // sender pause

		// radius phases, extremes included; each runs a share of random requests
		for (int ph = 0; ph < 6; ph++) begin
			write_radius(radii[ph]);
			// directed extremes under each radius
			send(pack_pair('0, '0, '0, '0, 32'd1800000000, 27'd50000000));
			send(pack_pair(31'h3FFFFFFF, 32'h80000000, 27'h4000000,
				31'h40000000, 32'h7FFFFFFF, 27'h3FFFFFF));
			for (int n = 0; n < 170; n++) begin
				if (ph == 1 && n == 20)
					no_idle = 1'b1;
				if (ph == 1 && n == 140)
					no_idle = 1'b0;
				if (ph == 3 && n == 30)
					fork
						begin
							rx_hold = 1'b1;
							repeat (600) @(posedge clk);
							rx_hold = 1'b0;
						end
					join_none
				send(random_pair());
			end
		end
		write_radius(23'($urandom_range(6000000, 7000000)));
		for (int n = 0; n < 40; n++)
			send(random_pair());

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("Sent %0d point pairs over 8 radius settings (0 and full scale included),",
			sent);
		$display("checked %0d distances with a 600-cycle output hold-off and a drain pause.",
			checked);
		if (fails == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
